[design/stack_alu_engine_macros.svh]
// ----------------------------------------------------------------------------
// stack_alu_engine_macros
// assertion macros shared by the stack engine checker
// ----------------------------------------------------------------------------
`ifndef STACK_ALU_ENGINE_MACROS_SVH
`define STACK_ALU_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sae_pkg.sv]
// ----------------------------------------------------------------------------
// sae_pkg
// types, codes and the microcode table of the stack engine
// ----------------------------------------------------------------------------
package sae_pkg;

	// field widths and default stack depth
	localparam int STACK_DEPTH_DEF = 64;
	localparam int WORD_W          = 32;
	localparam int LINE_W          = 16;
	localparam int ACT_W           = 3;
	localparam int ST_W            = 3;
	localparam int TDATA_W         = WORD_W + LINE_W;

	// operation codes
	localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PRINT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SWAP  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ADD   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SUB   = 3'd4;

	// result status codes
	localparam logic [ST_W-1:0] ST_DONE  = 3'd0;
	localparam logic [ST_W-1:0] ST_PRINT = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
	localparam logic [ST_W-1:0] ST_SHORT = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL  = 3'd4;

	// microprogram steps
	typedef enum logic [3:0] {
		UPC_IDLE,
		UPC_PUSH,
		UPC_FULL,
		UPC_SHORT,
		UPC_EMPTY,
		UPC_NOPZ,
		UPC_NOP0,
		UPC_NOP1,
		UPC_PR0,
		UPC_PR1,
		UPC_OP0,
		UPC_OP1,
		UPC_SW2,
		UPC_SW3,
		UPC_AS2
	} upc_t;

	typedef enum logic [1:0] {RD_NONE, RD_TOP, RD_SEC, RD_PTR} rd_sel_t;
	typedef enum logic [2:0] {WR_NONE, WR_PUSH, WR_TOP_RD, WR_SEC_A, WR_SEC_ALU} wr_sel_t;
	typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_t;
	typedef enum logic [2:0] {REG_NONE, REG_A, REG_B, REG_PTR_LOAD, REG_PTR_DEC} reg_op_t;
	typedef enum logic [2:0] {VS_ZERO, VS_PUSH, VS_RDATA, VS_B, VS_ALU} val_src_t;
	typedef enum logic [1:0] {J_NEXT, J_WAIT, J_OPSEL, J_LOOP} jmp_t;

	// one control word
	typedef struct packed {
		rd_sel_t         rd;
		wr_sel_t         wr;
		cnt_op_t         cnt_op;
		reg_op_t         reg_op;
		logic            emit;
		logic [ST_W-1:0] status;
		val_src_t        val_src;
		logic            line_en;
		logic            last_ptr;
		jmp_t            jmp;
		upc_t            nxt;
	} uc_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic empty;
		logic lt2;
		logic full;
		logic is_swap;
		logic ptr_zero;
	} seq_stat_t;

	// entry step for a newly accepted operation
	function automatic upc_t dispatch(logic [ACT_W-1:0] act, seq_stat_t st);
		upc_t u;
		case (act) inside
			ACT_PUSH:                   u = st.full ? UPC_FULL : UPC_PUSH;
			ACT_PRINT:                  u = st.empty ? UPC_EMPTY : UPC_PR0;
			ACT_SWAP, ACT_ADD, ACT_SUB: u = st.lt2 ? UPC_SHORT : UPC_OP0;
			default:                    u = st.empty ? UPC_NOPZ : UPC_NOP0;
		endcase
		return u;
	endfunction

	// microcode table
	function automatic uc_t uc_rom(upc_t upc);
		uc_t w;
		w = '{rd: RD_NONE, wr: WR_NONE, cnt_op: CNT_KEEP, reg_op: REG_NONE,
			emit: 1'b0, status: ST_DONE, val_src: VS_ZERO, line_en: 1'b0,
			last_ptr: 1'b0, jmp: J_NEXT, nxt: UPC_IDLE};
		case (upc)
			UPC_IDLE: begin
				w.jmp = J_WAIT;
			end
			UPC_PUSH: begin
				w.wr      = WR_PUSH;
				w.cnt_op  = CNT_INC;
				w.emit    = 1'b1;
				w.val_src = VS_PUSH;
			end
			UPC_FULL: begin
				w.cnt_op  = CNT_CLR;
				w.emit    = 1'b1;
				w.status  = ST_FULL;
				w.line_en = 1'b1;
			end
			UPC_SHORT: begin
				w.cnt_op  = CNT_CLR;
				w.emit    = 1'b1;
				w.status  = ST_SHORT;
				w.line_en = 1'b1;
			end
			UPC_EMPTY: begin
				w.emit   = 1'b1;
				w.status = ST_EMPTY;
			end
			UPC_NOPZ: begin
				w.emit = 1'b1;
			end
			UPC_NOP0: begin
				w.rd  = RD_TOP;
				w.nxt = UPC_NOP1;
			end
			UPC_NOP1: begin
				w.emit    = 1'b1;
				w.val_src = VS_RDATA;
			end
			UPC_PR0: begin
				w.rd     = RD_TOP;
				w.reg_op = REG_PTR_LOAD;
				w.nxt    = UPC_PR1;
			end
			UPC_PR1: begin
				w.rd       = RD_PTR;
				w.reg_op   = REG_PTR_DEC;
				w.emit     = 1'b1;
				w.status   = ST_PRINT;
				w.val_src  = VS_RDATA;
				w.last_ptr = 1'b1;
				w.jmp      = J_LOOP;
				w.nxt      = UPC_PR1;
			end
			UPC_OP0: begin
				w.rd  = RD_TOP;
				w.nxt = UPC_OP1;
			end
			UPC_OP1: begin
				w.rd     = RD_SEC;
				w.reg_op = REG_A;
				w.jmp    = J_OPSEL;
			end
			UPC_SW2: begin
				w.wr     = WR_TOP_RD;
				w.reg_op = REG_B;
				w.nxt    = UPC_SW3;
			end
			UPC_SW3: begin
				w.wr      = WR_SEC_A;
				w.emit    = 1'b1;
				w.val_src = VS_B;
			end
			UPC_AS2: begin
				w.wr      = WR_SEC_ALU;
				w.cnt_op  = CNT_DEC;
				w.emit    = 1'b1;
				w.val_src = VS_ALU;
			end
			default: begin
				w.jmp = J_NEXT;
			end
		endcase
		return w;
	endfunction

endpackage

[design/sae_ram.sv]
// ----------------------------------------------------------------------------
// sae_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sae_ram #(
	parameter int WIDTH = sae_pkg::WORD_W,
	parameter int DEPTH = sae_pkg::STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/sae_useq.sv]
// ----------------------------------------------------------------------------
// sae_useq
// step counter and jump logic over the microcode table
// ----------------------------------------------------------------------------
module sae_useq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [sae_pkg::ACT_W-1:0]      action,
	input  sae_pkg::seq_stat_t             stat,
	input  logic                           out_busy,
	output sae_pkg::uc_t                   uc,
	output logic                           in_ready,
	output logic                           advance
);

	import sae_pkg::*;

	upc_t upc_q;
	upc_t upc_nxt;

	// current control word, stall on a result step while the output is full
	assign uc       = uc_rom(upc_q);
	assign in_ready = (upc_q == UPC_IDLE);
	assign advance  = !(uc.emit && out_busy);

	// next step
	always_comb begin
		case (uc.jmp)
			J_WAIT:  upc_nxt = in_valid ? dispatch(action, stat) : UPC_IDLE;
			J_NEXT:  upc_nxt = uc.nxt;
			J_OPSEL: upc_nxt = stat.is_swap ? UPC_SW2 : UPC_AS2;
			J_LOOP:  upc_nxt = stat.ptr_zero ? UPC_IDLE : uc.nxt;
			default: upc_nxt = UPC_IDLE;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else if (advance) begin
			upc_q <= upc_nxt;
		end
	end

endmodule

[design/stack_alu_engine.sv]
// ----------------------------------------------------------------------------
// stack_alu_engine
// bounded integer stack with push, print all, swap, add and subtract
//
// channel  dir  handshake          payload
// s_*      in   tvalid / tready    tuser: action, tdata: push_value, src_line
// m_*      out  tvalid / tready    tuser: status, tdata: element_value,
//                                  error_line, tlast: last
//
// one microcode step per cycle unless stalled; ram: one read, one write port
// push, full, short, empty: direct result; no-op: reads top; add, subtract:
// read top, second, write result; swap: read both, write both; print: top down
// reset clears the element count, the step counter and the output valid
// a result step waits while the output register holds an untaken result
// ----------------------------------------------------------------------------
module stack_alu_engine #(
	parameter int STACK_DEPTH = sae_pkg::STACK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] push_value, [47:32] src_line
	input  logic [sae_pkg::TDATA_W-1:0]   s_tdata,
	// [2:0] action
	input  logic [sae_pkg::ACT_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] element_value, [47:32] error_line
	output logic [sae_pkg::TDATA_W-1:0]   m_tdata,
	// [2:0] status
	output logic [sae_pkg::ST_W-1:0]      m_tuser,
	output logic                          m_tlast
);

	import sae_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// control and item registers
	logic [CW-1:0]     cnt_q;
	logic [ACT_W-1:0]  act_q;
	logic [WORD_W-1:0] val_q;
	logic [LINE_W-1:0] line_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [AW-1:0]     ptr_q;

	logic              m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;
	logic [ST_W-1:0]   m_tuser_q;
	logic              m_tlast_q;

	uc_t               uc;
	seq_stat_t         stat;
	logic              advance;
	logic              accept;
	logic              emit_fire;

	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     cnt_m2;
	logic [AW-1:0]     top_addr;
	logic [AW-1:0]     sec_addr;
	logic [AW-1:0]     ptr_m1;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic [WORD_W-1:0] alu;
	logic [WORD_W-1:0] emit_val;

	// stack addresses
	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign top_addr = cnt_m1[AW-1:0];
	assign sec_addr = cnt_m2[AW-1:0];
	assign ptr_m1   = ptr_q - AW'(1);

	// status towards the sequencer
	assign stat.empty    = (cnt_q == '0);
	assign stat.lt2      = (cnt_q < CW'(2));
	assign stat.full     = (cnt_q == CW'(STACK_DEPTH));
	assign stat.is_swap  = (act_q == ACT_SWAP);
	assign stat.ptr_zero = (ptr_q == '0);

	sae_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.action   (s_tuser),
		.stat     (stat),
		.out_busy (m_tvalid_q && !m_tready),
		.uc       (uc),
		.in_ready (s_tready),
		.advance  (advance)
	);

	assign accept    = s_tvalid && s_tready;
	assign emit_fire = uc.emit && advance;

	// latch the incoming transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= s_tuser;
			val_q  <= s_tdata[WORD_W-1:0];
			line_q <= s_tdata[TDATA_W-1:WORD_W];
		end
	end

	// adder and subtractor, second element against the top
	assign alu = (act_q == ACT_ADD) ? (ram_rdata + a_q) : (ram_rdata - a_q);

	// read port
	always_comb begin
		case (uc.rd)
			RD_TOP:  ram_raddr = top_addr;
			RD_SEC:  ram_raddr = sec_addr;
			RD_PTR:  ram_raddr = ptr_m1;
			default: ram_raddr = '0;
		endcase
	end
	assign ram_re = advance && (uc.rd != RD_NONE) && !(uc.rd == RD_PTR && stat.ptr_zero);

	// write port
	always_comb begin
		case (uc.wr)
			WR_PUSH: begin
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = val_q;
			end
			WR_TOP_RD: begin
				ram_waddr = top_addr;
				ram_wdata = ram_rdata;
			end
			WR_SEC_A: begin
				ram_waddr = sec_addr;
				ram_wdata = a_q;
			end
			WR_SEC_ALU: begin
				ram_waddr = sec_addr;
				ram_wdata = alu;
			end
			default: begin
				ram_waddr = '0;
				ram_wdata = '0;
			end
		endcase
	end
	assign ram_we = advance && (uc.wr != WR_NONE);

	sae_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			case (uc.cnt_op)
				CNT_INC: cnt_q <= cnt_q + CW'(1);
				CNT_DEC: cnt_q <= cnt_m1;
				CNT_CLR: cnt_q <= '0;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// operand and print pointer registers
	always_ff @(posedge clk) begin
		if (advance) begin
			case (uc.reg_op)
				REG_A:        a_q   <= ram_rdata;
				REG_B:        b_q   <= ram_rdata;
				REG_PTR_LOAD: ptr_q <= top_addr;
				REG_PTR_DEC:  ptr_q <= ptr_m1;
				default:      ;
			endcase
		end
	end

	// result value
	always_comb begin
		case (uc.val_src)
			VS_PUSH:  emit_val = val_q;
			VS_RDATA: emit_val = ram_rdata;
			VS_B:     emit_val = b_q;
			VS_ALU:   emit_val = alu;
			default:  emit_val = '0;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= {(uc.line_en ? line_q : LINE_W'(0)), emit_val};
			m_tuser_q <= uc.status;
			m_tlast_q <= uc.last_ptr ? stat.ptr_zero : 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

[design/stack_alu_engine_chk.sv]
// ----------------------------------------------------------------------------
// stack_alu_engine_chk
// port-level checks on the result stream of the stack engine
// ----------------------------------------------------------------------------
`include "stack_alu_engine_macros.svh"

module stack_alu_engine_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [sae_pkg::TDATA_W-1:0] m_tdata,
	input logic [sae_pkg::ST_W-1:0]    m_tuser,
	input logic                        m_tlast
);

	import sae_pkg::*;

	// stalled result transaction holds
	`SAE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

	// only print results can be followed by more results of the same operation
	`SAE_ASSERT_IMPLY(a_single_last, clk, arst_n, m_tvalid && (m_tuser != ST_PRINT), m_tlast, "single result without last")

	// error line only on error results
	`SAE_ASSERT_IMPLY(a_line_zero, clk, arst_n, m_tvalid && (m_tuser != ST_SHORT) && (m_tuser != ST_FULL), m_tdata[TDATA_W-1:WORD_W] == '0, "error line on non-error result")

	// no element value on empty or error results
	`SAE_ASSERT_IMPLY(a_val_zero, clk, arst_n, m_tvalid && ((m_tuser == ST_EMPTY) || (m_tuser == ST_SHORT) || (m_tuser == ST_FULL)), m_tdata[WORD_W-1:0] == '0, "element value on empty or error result")

endmodule

bind stack_alu_engine stack_alu_engine_chk u_chk (.*);
